### rtl/nru_page_replacement_core_macros.svh
// Assertion macros for the NRU page replacement core.
// Needs clk and arst_n in the scope of every use; no other dependency.
`ifndef NRU_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define NRU_PAGE_REPLACEMENT_CORE_MACROS_SVH
`ifndef SYNTHESIS
// plain invariant, checked at every edge out of reset
`define NRU_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// same-cycle implication
`define NRU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define NRU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NRU_ASSERT(lbl, cond, msg)
`define NRU_ASSERT_IMPL(lbl, ante, cons, msg)
`define NRU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/nru_pkg.sv
// Shared types and constants of the NRU page replacement core.
// No dependencies; imported by the memory, modulo unit and top level.
package nru_pkg;

	localparam int PAGE_COUNT_DEF = 64;
	localparam int ADDR_W_MAX     = 10;
	localparam int PAGE_W         = 6;
	localparam int LFSR_W         = 16;
	localparam int INTERVAL_W     = 8;
	localparam int CFG_W          = 16;

	typedef enum logic [1:0] {
		OP_ACCESS = 2'd0,
		OP_LOAD   = 2'd1,
		OP_EVICT  = 2'd2,
		OP_VICTIM = 2'd3
	} op_t;

	typedef enum logic {
		CFG_CLEAR_INTERVAL = 1'b0,
		CFG_RANDOM_SEED    = 1'b1
	} cfg_idx_t;

	localparam logic STATUS_DONE  = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	localparam logic [LFSR_W-1:0] LFSR_RESET   = 16'd1;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd8;

	typedef struct packed {
		op_t                opcode;
		logic [PAGE_W-1:0]  page;
		logic               is_write;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0]  victim_page;
		logic [1:0]         victim_class;
		logic               status;
	} rsp_t;

	typedef struct packed {
		logic present;
		logic dirty;
	} pd_bits_t;

	typedef struct packed {
		logic present;
		logic referenced;
		logic dirty;
	} page_bits_t;

	// one read port and one write address shared by both arrays
	typedef struct packed {
		logic                  rd_en;
		logic [ADDR_W_MAX-1:0] rd_addr;
		logic                  pd_we;
		pd_bits_t              pd_wdata;
		logic                  r_we;
		logic                  r_wdata;
		logic [ADDR_W_MAX-1:0] wr_addr;
	} mem_req_t;

endpackage

### rtl/nru_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
// Payload type is set per instance; no package dependency.
interface nru_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/nru_page_replacement_core.sv
// Not-recently-used page replacement core: controller, counters, LFSR.
// Uses nru_pkg, nru_chan_if, nru_mem, nru_mod and the assertion macros.
//
// Usage:
//  - req (sink): one transaction per operation {opcode, page, is_write}.
//    rsp (source): exactly one transaction per request
//    {victim_page, victim_class, status}, in request order.
//  - cfg_we/cfg_index/cfg_data write clear_interval (index 0) or
//    random_seed (index 1, also loads the LFSR; zero loads 1). Write only
//    while the core is idle.
//  - One operation is in flight at a time. Access, load and evict read and
//    write back one memory entry, then the response is loaded into the
//    output register. An access that hits the clear interval is followed by
//    a sweep over every entry clearing all referenced bits.
//  - Victim search makes two passes over the memory (count classes, then
//    locate the chosen member) around an iterative modulo, one read per
//    entry on the single read port; an empty table ends after the count.
//  - Reset: a sweep zeroes all entries; req.ready is low until it ends.
//    Config writes are taken meanwhile.
//  - A stalled rsp holds its transaction; the core still takes the next
//    request and parks its result until the output register frees.
`include "nru_page_replacement_core_macros.svh"
module nru_page_replacement_core
	import nru_pkg::*;
#(
	parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	nru_chan_if.sink        req,
	nru_chan_if.source      rsp,
	input  logic            cfg_we,
	input  cfg_idx_t        cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	localparam int AW = $clog2(PAGE_COUNT);
	localparam int CW = $clog2(PAGE_COUNT + 1);
	localparam logic [AW-1:0] LAST = AW'(PAGE_COUNT - 1);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_OPWR  = 8'b0000_0100,
		ST_RESP  = 8'b0000_1000,
		ST_CNT   = 8'b0001_0000,
		ST_SEL   = 8'b0010_0000,
		ST_MOD   = 8'b0100_0000,
		ST_PICK  = 8'b1000_0000
	} state_t;

	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
		logic fb;
		fb = v[15] ^ v[13] ^ v[12] ^ v[10];
		return {v[LFSR_W-2:0], fb};
	endfunction

	state_t                state_q;
	op_t                   op_q;
	logic                  wr_q;
	logic                  ok_q;
	logic [INTERVAL_W-1:0] interval_q;
	logic [INTERVAL_W-1:0] counter_q;
	logic [LFSR_W-1:0]     lfsr_q;
	logic                  clr_all_q;
	logic                  clr_pend_q;
	logic [AW-1:0]         scan_addr_q;
	logic                  issue_done_q;
	logic                  rd_vld_s1;
	logic [AW-1:0]         rd_addr_s1;
	logic [CW-1:0]         counts_q [4];
	logic [1:0]            best_q;
	logic [CW-1:0]         sel_cnt_q;
	logic [CW-1:0]         pick_q;
	logic [CW-1:0]         seen_q;
	logic                  found_q;
	logic [AW-1:0]         victim_q;
	rsp_t                  res_q;
	logic                  out_valid_q;
	rsp_t                  out_data_q;

	mem_req_t              mreq;
	page_bits_t            rdata;
	logic                  acc;
	logic                  in_ok;
	logic                  issue_en;
	logic [1:0]            rd_cls;
	logic                  match;
	logic                  hit_now;
	logic                  scan_last;
	logic                  sel_none;
	logic [1:0]            sel_best;
	logic [CW-1:0]         sel_cnt;
	logic                  mod_start;
	logic                  mod_done;
	logic [CW-1:0]         mod_rem;
	logic                  out_free;
	logic [AW-1:0]         pick_addr;

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	assign acc      = req.valid && req.ready;
	assign in_ok    = int'(req.data.page) < PAGE_COUNT;
	assign issue_en = ((state_q == ST_CNT) || (state_q == ST_PICK)) && !issue_done_q;
	assign rd_cls   = {rdata.referenced, rdata.dirty};
	assign scan_last = rd_vld_s1 && (rd_addr_s1 == LAST);
	assign match    = rd_vld_s1 && rdata.present && (rd_cls == best_q) && !found_q;
	assign hit_now  = (state_q == ST_PICK) && match && (seen_q == pick_q);
	assign pick_addr = hit_now ? rd_addr_s1 : victim_q;
	assign out_free = !out_valid_q || rsp.ready;
	assign mod_start = (state_q == ST_SEL) && !sel_none;

	// lowest non-empty class
	always_comb begin
		sel_none = 1'b0;
		sel_best = 2'd0;
		sel_cnt  = counts_q[0];
		priority if (counts_q[0] != '0) begin
			sel_best = 2'd0;
			sel_cnt  = counts_q[0];
		end else if (counts_q[1] != '0) begin
			sel_best = 2'd1;
			sel_cnt  = counts_q[1];
		end else if (counts_q[2] != '0) begin
			sel_best = 2'd2;
			sel_cnt  = counts_q[2];
		end else if (counts_q[3] != '0) begin
			sel_best = 2'd3;
			sel_cnt  = counts_q[3];
		end else begin
			sel_none = 1'b1;
		end
	end

	// memory requests
	always_comb begin
		mreq = '0;
		if (acc && in_ok && (req.data.opcode != OP_VICTIM)) begin
			mreq.rd_en   = 1'b1;
			mreq.rd_addr = ADDR_W_MAX'(AW'(req.data.page));
		end
		if (issue_en) begin
			mreq.rd_en   = 1'b1;
			mreq.rd_addr = ADDR_W_MAX'(scan_addr_q);
		end
		if (state_q == ST_OPWR && ok_q) begin
			mreq.wr_addr = ADDR_W_MAX'(victim_q);
			unique case (op_q)
				OP_ACCESS: begin
					mreq.pd_we    = 1'b1;
					mreq.pd_wdata = '{present: rdata.present, dirty: rdata.dirty | wr_q};
					mreq.r_we     = 1'b1;
					mreq.r_wdata  = 1'b1;
				end
				OP_LOAD: begin
					mreq.pd_we    = 1'b1;
					mreq.pd_wdata = '{present: 1'b1, dirty: rdata.dirty};
				end
				OP_EVICT: begin
					mreq.pd_we    = 1'b1;
					mreq.pd_wdata = '{present: 1'b0, dirty: 1'b0};
				end
				default: begin
					mreq.pd_we = 1'b0;
				end
			endcase
		end
		if (state_q == ST_CLEAR) begin
			// reset sweep zeroes everything, interval sweep only referenced
			mreq.wr_addr  = ADDR_W_MAX'(scan_addr_q);
			mreq.r_we     = 1'b1;
			mreq.r_wdata  = 1'b0;
			mreq.pd_we    = clr_all_q;
			mreq.pd_wdata = '0;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_all_q    <= 1'b1;
			clr_pend_q   <= 1'b0;
			scan_addr_q  <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			counter_q    <= '0;
			interval_q   <= INTERVAL_RESET;
			lfsr_q       <= LFSR_RESET;
		end else begin
			rd_vld_s1 <= issue_en;
			if (issue_en) begin
				if (scan_addr_q == LAST) begin
					issue_done_q <= 1'b1;
				end else begin
					scan_addr_q <= scan_addr_q + AW'(1);
				end
			end
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (scan_addr_q == LAST) begin
						scan_addr_q <= '0;
						clr_all_q   <= 1'b0;
						clr_pend_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end else begin
						scan_addr_q <= scan_addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (acc) begin
						scan_addr_q  <= '0;
						issue_done_q <= 1'b0;
						if (req.data.opcode == OP_VICTIM) begin
							state_q <= ST_CNT;
						end else begin
							state_q <= ST_OPWR;
						end
					end
				end
				ST_OPWR: begin
					if (ok_q && op_q == OP_ACCESS) begin
						if (counter_q == interval_q) begin
							counter_q  <= '0;
							clr_pend_q <= 1'b1;
						end else begin
							counter_q <= counter_q + INTERVAL_W'(1);
						end
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						scan_addr_q <= '0;
						state_q     <= clr_pend_q ? ST_CLEAR : ST_IDLE;
					end
				end
				ST_CNT: begin
					if (scan_last) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					state_q <= sel_none ? ST_RESP : ST_MOD;
				end
				ST_MOD: begin
					if (mod_done) begin
						lfsr_q       <= lfsr_next(lfsr_q);
						scan_addr_q  <= '0;
						issue_done_q <= 1'b0;
						found_q      <= 1'b0;
						state_q      <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (hit_now) begin
						found_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= ST_RESP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CLEAR_INTERVAL: interval_q <= cfg_data[INTERVAL_W-1:0];
					CFG_RANDOM_SEED:    lfsr_q <= (cfg_data == '0) ? LFSR_RESET : cfg_data;
					default:            interval_q <= interval_q;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		rd_addr_s1 <= scan_addr_q;
		if (acc) begin
			op_q     <= req.data.opcode;
			wr_q     <= req.data.is_write;
			ok_q     <= in_ok;
			victim_q <= AW'(req.data.page);
			for (int c = 0; c < 4; c++) begin
				counts_q[c] <= '0;
			end
		end
		if (state_q == ST_OPWR) begin
			res_q <= '{victim_page: '0, victim_class: 2'd0, status: STATUS_DONE};
		end
		if (state_q == ST_CNT && rd_vld_s1 && rdata.present) begin
			for (int c = 0; c < 4; c++) begin
				if (rd_cls == 2'(c)) begin
					counts_q[c] <= counts_q[c] + CW'(1);
				end
			end
		end
		if (state_q == ST_SEL) begin
			best_q    <= sel_best;
			sel_cnt_q <= sel_cnt;
			res_q     <= '{victim_page: '0, victim_class: 2'd0, status: STATUS_EMPTY};
		end
		if (state_q == ST_MOD && mod_done) begin
			pick_q <= mod_rem;
			seen_q <= '0;
		end
		if (state_q == ST_PICK) begin
			if (match && !hit_now) begin
				seen_q <= seen_q + CW'(1);
			end
			if (hit_now) begin
				victim_q <= rd_addr_s1;
			end
			if (scan_last) begin
				res_q <= '{victim_page: PAGE_W'(pick_addr), victim_class: best_q,
					status: STATUS_DONE};
			end
		end
		if (state_q == ST_RESP && out_free) begin
			out_data_q <= res_q;
		end
	end

	nru_mem #(
		.PAGE_COUNT (PAGE_COUNT)
	) u_mem (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	nru_mod #(
		.PAGE_COUNT (PAGE_COUNT)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (lfsr_q),
		.divisor  (sel_cnt),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	`NRU_ASSERT(a_lfsr_nonzero, lfsr_q != '0, "LFSR reached the all-zero lockup value")
	`NRU_ASSERT_IMPL(a_mod_range, (state_q == ST_MOD) && mod_done, mod_rem < sel_cnt_q, "modulo result not below class count")
	`NRU_ASSERT_IMPL(a_pick_found, (state_q == ST_PICK) && scan_last, found_q || hit_now, "victim scan ended without locating chosen member")
	`NRU_ASSERT_IMPL(a_empty_zero, out_valid_q && (out_data_q.status == STATUS_EMPTY), (out_data_q.victim_page == '0) && (out_data_q.victim_class == 2'd0), "empty search response carries nonzero fields")
endmodule

### rtl/nru_mem.sv
// Page state storage: present/dirty array and referenced array.
// Uses nru_pkg; one registered read port, one write address per cycle.
module nru_mem
	import nru_pkg::*;
#(
	parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
	input  logic       clk,
	input  mem_req_t   mreq,
	output page_bits_t rdata
);
	localparam int AW = $clog2(PAGE_COUNT);

	pd_bits_t pd_mem [PAGE_COUNT];
	logic     r_mem  [PAGE_COUNT];

	always_ff @(posedge clk) begin
		if (mreq.pd_we) begin
			pd_mem[mreq.wr_addr[AW-1:0]] <= mreq.pd_wdata;
		end
		if (mreq.r_we) begin
			r_mem[mreq.wr_addr[AW-1:0]] <= mreq.r_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.rd_en) begin
			rdata.present    <= pd_mem[mreq.rd_addr[AW-1:0]].present;
			rdata.dirty      <= pd_mem[mreq.rd_addr[AW-1:0]].dirty;
			rdata.referenced <= r_mem[mreq.rd_addr[AW-1:0]];
		end
	end
endmodule

### rtl/nru_mod.sv
// Iterative restoring modulo: LFSR value mod class count, one bit a cycle.
// Uses nru_pkg for the dividend width.
module nru_mod
	import nru_pkg::*;
#(
	parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [LFSR_W-1:0] dividend,
	input  logic [$clog2(PAGE_COUNT+1)-1:0] divisor,
	output logic              done,
	output logic [$clog2(PAGE_COUNT+1)-1:0] rem
);
	localparam int CW = $clog2(PAGE_COUNT + 1);
	localparam int SW = $clog2(LFSR_W + 1);

	logic [CW-1:0]     rem_q;
	logic [CW-1:0]     div_q;
	logic [LFSR_W-1:0] quo_q;
	logic [SW-1:0]     step_q;
	logic              busy_q;
	logic              done_q;
	logic [CW:0]       trial;
	logic [CW:0]       diff;

	assign trial = {rem_q, quo_q[LFSR_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(LFSR_W);
			end else if (busy_q) begin
				step_q <= step_q - SW'(1);
				if (step_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			quo_q <= {quo_q[LFSR_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[CW-1:0];
			end else begin
				rem_q <= trial[CW-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

### sim/tb_nru_page_replacement_core.sv
// Self-checking testbench for nru_page_replacement_core: every response is checked against
// a cycle-free NRU predictor. Depends on nru_pkg, nru_chan_if and the core RTL.
`timescale 1ns / 100ps
module tb_nru_page_replacement_core;
	import nru_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 10;
	// the sweep after a clear-interval hit runs on past the response
	localparam int SETTLE_CYCLES = PAGE_COUNT_DEF + 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_MAX    = 10;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	cfg_idx_t        cfg_index;
	logic [CFG_W-1:0] cfg_data;

	nru_chan_if #(.payload_t(req_t)) req_if ();
	nru_chan_if #(.payload_t(rsp_t)) rsp_if ();

	nru_page_replacement_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.rsp      (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Predictor state: a shadow of the page table, the access counter and the LFSR.
	logic [PAGE_COUNT_DEF-1:0] shadow_present;
	logic [PAGE_COUNT_DEF-1:0] shadow_referenced;
	logic [PAGE_COUNT_DEF-1:0] shadow_dirty;
	logic [INTERVAL_W-1:0]     shadow_access_cnt;
	logic [INTERVAL_W-1:0]     shadow_clear_interval;
	logic [LFSR_W-1:0]         shadow_lfsr;

	req_t page_op_q[$];       // operations waiting to be offered
	rsp_t victim_rsp_q[$];    // expected responses, oldest first

	int  cycle_cnt;
	int  mismatch_cnt;
	int  send_gap_pct;
	int  recv_stall_pct;
	int  holds_asked;
	int  holds_served;
	int  hold_left;
	bit  op_taken;            // request transaction at the last rising edge

	// Apply one operation to the shadow state and return the response it must produce.
	function automatic rsp_t apply_page_op(req_t op);
		rsp_t res;
		int   class_cnt[4];
		int   best;
		int   pick;
		int   seen;
		res = '0;
		class_cnt = '{0, 0, 0, 0};
		case (op.opcode)
			OP_ACCESS: begin
				shadow_referenced[op.page] = 1'b1;
				if (op.is_write)
					shadow_dirty[op.page] = 1'b1;
				// the clear wipes the bit that was just set as well
				if (shadow_access_cnt == shadow_clear_interval) begin
					shadow_referenced = '0;
					shadow_access_cnt = '0;
				end else begin
					shadow_access_cnt = shadow_access_cnt + 1'b1;
				end
			end
			OP_LOAD: begin
				// referenced and dirty survive a load
				shadow_present[op.page] = 1'b1;
			end
			OP_EVICT: begin
				shadow_present[op.page] = 1'b0;
				shadow_dirty[op.page]   = 1'b0;
			end
			OP_VICTIM: begin
				for (int p = 0; p < PAGE_COUNT_DEF; p++)
					if (shadow_present[p])
						class_cnt[{shadow_referenced[p], shadow_dirty[p]}]++;
				best = 4;
				for (int c = 3; c >= 0; c--)
					if (class_cnt[c] != 0)
						best = c;
				if (best == 4) begin
					// nothing present: error status, LFSR untouched
					res.status = STATUS_EMPTY;
				end else begin
					pick = int'(shadow_lfsr) % class_cnt[best];
					shadow_lfsr = {shadow_lfsr[LFSR_W-2:0],
						shadow_lfsr[15] ^ shadow_lfsr[13] ^ shadow_lfsr[12] ^ shadow_lfsr[10]};
					seen = 0;
					for (int p = 0; p < PAGE_COUNT_DEF; p++) begin
						if (shadow_present[p] &&
								{shadow_referenced[p], shadow_dirty[p]} == best[1:0]) begin
							if (seen == pick) begin
								res.victim_page  = p[PAGE_W-1:0];
								res.victim_class = best[1:0];
							end
							seen++;
						end
					end
					res.status = STATUS_DONE;
				end
			end
		endcase
		return res;
	endfunction

	initial begin
		clk = 1'b0;
	end
	always #(CLK_HALF) clk = ~clk;

	// Request driver: changes only on the falling edge, holds data until the transaction.
	always @(negedge clk) begin
		req_t nxt;
		if (!req_if.valid || op_taken) begin
			if (page_op_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				nxt = page_op_q.pop_front();
				req_if.data  <= nxt;
				req_if.valid <= 1'b1;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// Response ready: random stalls, plus a long hold-off on request so the core backs up
	// and drops req.ready while the driver keeps offering.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_if.ready <= 1'b0;
		end else if (holds_asked != holds_served) begin
			holds_served = holds_served + 1;
			hold_left    = HOLD_CYCLES;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predict on every request transaction, check every response transaction.
	always @(posedge clk) begin
		rsp_t want;
		cycle_cnt = cycle_cnt + 1;
		op_taken  = arst_n && req_if.valid && req_if.ready;
		if (op_taken)
			victim_rsp_q.push_back(apply_page_op(req_if.data));
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (victim_rsp_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= REPORT_MAX)
					$display("%0t: response with none pending: page %0d class %0d status %0b",
						$realtime, rsp_if.data.victim_page, rsp_if.data.victim_class,
						rsp_if.data.status);
			end else begin
				want = victim_rsp_q.pop_front();
				if (rsp_if.data.victim_page !== want.victim_page ||
						rsp_if.data.victim_class !== want.victim_class ||
						rsp_if.data.status !== want.status) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_MAX)
						$display("%0t: mismatch: expected page %0d class %0d status %0b, got page %0d class %0d status %0b",
							$realtime, want.victim_page, want.victim_class, want.status,
							rsp_if.data.victim_page, rsp_if.data.victim_class,
							rsp_if.data.status);
				end
			end
		end
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic queue_op(op_t opc, int pg, bit wr);
		req_t op;
		op.opcode   = opc;
		op.page     = pg[PAGE_W-1:0];
		op.is_write = wr;
		page_op_q.push_back(op);
	endtask

	// Register write on the falling edge; the shadow copy follows at once since the
	// core is idle whenever this runs.
	task automatic write_cfg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CLEAR_INTERVAL) begin
			shadow_clear_interval = val[INTERVAL_W-1:0];
		end else begin
			// zero seed would lock the LFSR, so the core loads 1
			shadow_lfsr = (val == '0) ? LFSR_RESET : val;
		end
	endtask

	task automatic set_idle(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_gap_pct   = 65;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_gap_pct   = 0;
				recv_stall_pct = 65;
			end
			default: begin
				send_gap_pct   = 19;
				recv_stall_pct = 19;
			end
		endcase
	endtask

	// Mostly accesses and loads so victim search sees a populated table; a quarter of
	// the pages come from a narrow window so the same pages are hit over and over.
	task automatic queue_random_ops(int n, int access_pct);
		int r;
		int pg;
		op_t opc;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < access_pct)
				opc = OP_ACCESS;
			else if (r < access_pct + (100 - access_pct) * 2 / 5)
				opc = OP_LOAD;
			else if (r < access_pct + (100 - access_pct) * 3 / 5)
				opc = OP_EVICT;
			else
				opc = OP_VICTIM;
			pg = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(PAGE_COUNT_DEF - 1);
			queue_op(opc, pg, $urandom_range(1));
		end
	endtask

	// Wait for all queued operations to be answered, then for any trailing sweep.
	task automatic drain();
		while (page_op_q.size() != 0 || req_if.valid || victim_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(idle_mode_t mode, logic [CFG_W-1:0] interval,
			logic [CFG_W-1:0] seed, int n, int access_pct, bit hold);
		write_cfg(CFG_CLEAR_INTERVAL, interval);
		write_cfg(CFG_RANDOM_SEED, seed);
		set_idle(mode);
		if (hold)
			holds_asked++;
		queue_random_ops(n, access_pct);
		drain();
	endtask

	initial begin
		// known values on every input before anything else happens
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_CLEAR_INTERVAL;
		cfg_data       = '0;
		req_if.valid   = 1'b0;
		req_if.data    = '0;
		rsp_if.ready   = 1'b0;
		cycle_cnt      = 0;
		mismatch_cnt   = 0;
		holds_asked    = 0;
		holds_served   = 0;
		hold_left      = 0;
		op_taken       = 1'b0;
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		shadow_present        = '0;
		shadow_referenced     = '0;
		shadow_dirty          = '0;
		shadow_access_cnt     = '0;
		shadow_clear_interval = INTERVAL_RESET;
		shadow_lfsr           = LFSR_RESET;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed part at reset configuration. Search on an empty table first.
		set_idle(IDLE_NONE);
		queue_op(OP_VICTIM, 0, 1'b0);
		// write access to an absent page still sets its bits
		queue_op(OP_ACCESS, 5, 1'b1);
		queue_op(OP_LOAD, 0, 1'b0);
		queue_op(OP_LOAD, PAGE_COUNT_DEF - 1, 1'b1);
		queue_op(OP_LOAD, 5, 1'b0);
		queue_op(OP_VICTIM, PAGE_COUNT_DEF - 1, 1'b1);
		queue_op(OP_VICTIM, 0, 1'b0);
		queue_op(OP_ACCESS, 0, 1'b0);
		queue_op(OP_ACCESS, PAGE_COUNT_DEF - 1, 1'b1);
		queue_op(OP_VICTIM, 0, 1'b0);
		// evict drops the dirty bit; reload keeps the referenced bit
		queue_op(OP_EVICT, 5, 1'b0);
		queue_op(OP_EVICT, PAGE_COUNT_DEF - 1, 1'b1);
		queue_op(OP_VICTIM, 0, 1'b0);
		queue_op(OP_LOAD, PAGE_COUNT_DEF - 1, 1'b0);
		queue_op(OP_VICTIM, 0, 1'b0);
		// reach the clear interval: the counter sits at 3 here
		for (int i = 0; i < 6; i++)
			queue_op(OP_ACCESS, i * 11, i[0]);
		queue_op(OP_VICTIM, 0, 1'b0);
		queue_op(OP_EVICT, 0, 1'b0);
		queue_op(OP_EVICT, PAGE_COUNT_DEF - 1, 1'b0);
		queue_op(OP_VICTIM, PAGE_COUNT_DEF - 1, 1'b1);
		drain();

		// Random phases over register extremes and idling styles. Zero seed maps to 1,
		// interval zero clears on every access.
		run_phase(IDLE_SEND, 16'd0, 16'd0, 50, 45, 1'b0);
		run_phase(IDLE_RECV, 16'd255, 16'hFFFF, 60, 40, 1'b1);
		run_phase(IDLE_BOTH, 16'($urandom_range(1, 20)), 16'($urandom_range(1, 65535)),
			60, 45, 1'b0);
		run_phase(IDLE_NONE, 16'd3, 16'd1, 60, 50, 1'b0);
		// counter runs up at a high interval, then the interval drops below it
		run_phase(IDLE_BOTH, 16'd200, 16'($urandom_range(1, 65535)), 80, 85, 1'b0);
		run_phase(IDLE_SEND, 16'($urandom_range(1, 12)), 16'($urandom_range(1, 65535)),
			90, 60, 1'b0);

		if (mismatch_cnt == 0 && victim_rsp_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
